[hw/rtl/mlm_pkg.sv]
// Package: shared constants and status codes for the mutex lock manager.
package mlm_pkg;
    localparam int NUM_PROCS_DEF   = 8;
    localparam int NUM_MUTEXES_DEF = 8;
    localparam int ID_W  = 3;
    localparam int ST_W  = 3;
    localparam logic [ST_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [ST_W-1:0] ST_DEADLOCK = 3'd2;
    localparam logic [ST_W-1:0] ST_UNREG    = 3'd3;
    localparam logic [ST_W-1:0] ST_RELEASED = 3'd4;
    localparam logic [ST_W-1:0] ST_INVALID  = 3'd5;
    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;
endpackage

[hw/rtl/mlm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/mutex_lock_manager_deadlock_check.sv]
// Top level: mutex lock manager with wait-for deadlock check.
//
// Requests enter on the in channel (opcode, process_id, mutex_index) and each
// gives one result on the out channel (status, next_owner, next_owner_valid).
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The mask register sits at APB address 0; the user must write it only
// while the block is idle (not enforced by the block). One request is handled
// at a time; the next is taken in the cycle after its result leaves. A range or
// mask reject goes straight to the output register; a grant, a plain release
// or an invalid lock/unlock passes the read and decode states. Each deadlock
// chain walk step is a test, waits read and owner read (at most NUM_PROCS
// steps); the walk ends in the test on a deadlock and passes the owner check
// at the step bound. A handoff on unlock adds a FIFO read, pop and clear of the
// new owner's wait. The result sits in an output register; while the receiver
// stalls, the block holds it and takes no new request. A sweep after reset over
// max(NUM_PROCS, NUM_MUTEXES) addresses clears the owner and waits memories; no
// request is accepted during it. The waiter FIFO needs no clearing: only
// entries inside a live count are read. Reset clears the mask to zero.
module mutex_lock_manager_deadlock_check
    import mlm_pkg::*;
#(
    parameter int NUM_PROCS   = NUM_PROCS_DEF,
    parameter int NUM_MUTEXES = NUM_MUTEXES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic [mlm_pkg::ID_W-1:0]  process_id,
    input  logic [mlm_pkg::ID_W-1:0]  mutex_index,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [mlm_pkg::ST_W-1:0]  status,
    output logic [mlm_pkg::ID_W-1:0]  next_owner,
    output logic                      next_owner_valid
);
    localparam int PW   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int MW   = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int CW   = $clog2(NUM_PROCS + 1);
    localparam int FD   = NUM_MUTEXES * NUM_PROCS;
    localparam int FW   = $clog2(FD);
    localparam int MAXN = (NUM_PROCS > NUM_MUTEXES) ? NUM_PROCS : NUM_MUTEXES;
    localparam int SW   = $clog2(MAXN + 1);
    // owner word: valid, process, head, count
    localparam int OWW  = 1 + PW + PW + CW;
    // waits word: valid, mutex
    localparam int WWW  = 1 + MW;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_WRD   = 4'd4;
    localparam logic [3:0] S_WCHK  = 4'd5;
    localparam logic [3:0] S_OCHK  = 4'd6;
    localparam logic [3:0] S_FRD   = 4'd7;
    localparam logic [3:0] S_FPOP  = 4'd8;
    localparam logic [3:0] S_WCLR  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]      state_reg, state_next;
    logic [SW-1:0]   clr_reg, clr_next;
    logic [7:0]      mask_reg;
    logic            op_reg, op_next;
    logic [ID_W-1:0] pid_reg, pid_next;
    logic [ID_W-1:0] mid_reg, mid_next;
    logic [OWW-1:0]  ow_reg, ow_next;        // owner word of addressed mutex
    logic [PW-1:0]   q_reg, q_next;          // chain walk process
    logic [SW-1:0]   step_reg, step_next;
    logic [ST_W-1:0] st_reg, st_next;
    logic [ID_W-1:0] nx_reg, nx_next;
    logic            nxv_reg, nxv_next;
    logic [PW-1:0]   w_reg, w_next;

    // memory ports
    logic            o_we, w_we, f_we;
    logic [MW-1:0]   o_waddr, o_raddr;
    logic [OWW-1:0]  o_wdata, o_rdata;
    logic [PW-1:0]   w_waddr, w_raddr;
    logic [WWW-1:0]  w_wdata, w_rdata;
    logic [FW-1:0]   f_waddr, f_raddr;
    logic [PW-1:0]   f_wdata, f_rdata;

    mlm_ram #(.WIDTH(OWW), .DEPTH(NUM_MUTEXES)) u_owner (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata));
    mlm_ram #(.WIDTH(WWW), .DEPTH(NUM_PROCS)) u_waits (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata));
    mlm_ram #(.WIDTH(PW), .DEPTH(FD)) u_fifo (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));

    // fields of the latched owner word
    logic          ow_v;
    logic [PW-1:0] ow_p, ow_h;
    logic [CW-1:0] ow_c;
    assign {ow_v, ow_p, ow_h, ow_c} = ow_reg;

    logic          ro_v;
    logic [PW-1:0] ro_p, ro_h;
    logic [CW-1:0] ro_c;
    assign {ro_v, ro_p, ro_h, ro_c} = o_rdata;

    logic          rw_v;
    logic [MW-1:0] rw_m;
    assign {rw_v, rw_m} = w_rdata;

    logic [PW-1:0] pid_p;
    logic [MW-1:0] mid_m;
    assign pid_p = pid_reg[PW-1:0];
    assign mid_m = mid_reg[MW-1:0];

    logic [PW:0]   slot_sum;
    logic [PW-1:0] slot, head_inc;
    assign slot_sum = {1'b0, ow_h} + (PW+1)'(ow_c) - ((PW+1)'(ow_h) + (PW+1)'(ow_c) >=
                      (PW+1)'(NUM_PROCS) ? (PW+1)'(NUM_PROCS) : '0);
    assign slot     = slot_sum[PW-1:0];
    assign head_inc = ({1'b0, ow_h} + 1'b1 >= (PW+1)'(NUM_PROCS)) ? '0 : ow_h + 1'b1;

    logic [FW-1:0] fbase;
    assign fbase = FW'(mid_m) * FW'(NUM_PROCS);

    logic apb_wr;
    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {24'd0, mask_reg} : 32'd0;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status           = st_reg;
    assign next_owner       = nx_reg;
    assign next_owner_valid = nxv_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        pid_next   = pid_reg;
        mid_next   = mid_reg;
        ow_next    = ow_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        st_next    = st_reg;
        nx_next    = nx_reg;
        nxv_next   = nxv_reg;
        w_next     = w_reg;
        o_we = 1'b0; o_waddr = mid_m; o_wdata = ow_reg; o_raddr = mid_m;
        w_we = 1'b0; w_waddr = pid_p; w_wdata = '0;     w_raddr = pid_p;
        f_we = 1'b0; f_waddr = fbase + FW'(slot); f_wdata = pid_p;
        f_raddr = fbase + FW'(ow_h);
        case (state_reg)
            S_CLR:
            begin
                o_we = (clr_reg < SW'(NUM_MUTEXES));
                o_waddr = clr_reg[MW-1:0];
                o_wdata = '0;
                w_we = (clr_reg < SW'(NUM_PROCS));
                w_waddr = clr_reg[PW-1:0];
                w_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(MAXN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode;
                    pid_next = process_id;
                    mid_next = mutex_index;
                    nx_next  = '0;
                    nxv_next = 1'b0;
                    if ({1'b0, mutex_index} >= (ID_W+1)'(NUM_MUTEXES) ||
                        (opcode == OP_LOCK &&
                         {1'b0, process_id} >= (ID_W+1)'(NUM_PROCS)))
                    begin
                        st_next = ST_INVALID;
                        state_next = S_OUT;
                    end
                    else if (!mask_reg[mutex_index])
                    begin
                        st_next = ST_UNREG;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                // reads of owner[m] and waits[p] are in flight
                state_next = S_DEC;
            end
            S_DEC:
            begin
                ow_next = o_rdata;
                if (op_reg == OP_LOCK)
                begin
                    if (rw_v)
                    begin
                        st_next = ST_INVALID;
                        state_next = S_OUT;
                    end
                    else if (!ro_v)
                    begin
                        o_we = 1'b1;
                        o_wdata = {1'b1, pid_p, ro_h, ro_c};
                        st_next = ST_GRANTED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        q_next = ro_p;
                        step_next = '0;
                        state_next = S_WCHK;
                    end
                end
                else
                begin
                    if (!ro_v)
                    begin
                        st_next = ST_INVALID;
                        state_next = S_OUT;
                    end
                    else if (ro_c != '0)
                    begin
                        state_next = S_FRD;
                    end
                    else
                    begin
                        o_we = 1'b1;
                        o_wdata = '0;
                        st_next = ST_RELEASED;
                        state_next = S_OUT;
                    end
                end
            end
            S_WCHK:
            begin
                // test q, then issue waits read for q
                if (q_reg == pid_p)
                begin
                    st_next = ST_DEADLOCK;
                    state_next = S_OUT;
                end
                else if (step_reg == SW'(NUM_PROCS))
                begin
                    state_next = S_OCHK;
                    step_next = '1;
                end
                else
                begin
                    w_raddr = q_reg;
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                // waits[q] valid now: follow to owner of that mutex
                if (!rw_v)
                begin
                    step_next = '1;
                    state_next = S_OCHK;
                end
                else
                begin
                    o_raddr = rw_m;
                    state_next = S_OCHK;
                end
            end
            S_OCHK:
            begin
                if (step_reg == '1 || !ro_v)
                begin
                    // no cycle: enqueue, unless the queue is full
                    if (ow_c >= CW'(NUM_PROCS))
                    begin
                        st_next = ST_INVALID;
                    end
                    else
                    begin
                        f_we = 1'b1;
                        o_we = 1'b1;
                        o_wdata = {ow_v, ow_p, ow_h, ow_c + 1'b1};
                        w_we = 1'b1;
                        w_wdata = {1'b1, mid_m};
                        st_next = ST_QUEUED;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    q_next = ro_p;
                    step_next = step_reg + 1'b1;
                    state_next = S_WCHK;
                end
            end
            S_FRD:
            begin
                state_next = S_FPOP;
            end
            S_FPOP:
            begin
                w_next = f_rdata;
                o_we = 1'b1;
                o_wdata = {1'b1, f_rdata, head_inc, ow_c - 1'b1};
                nx_next = ID_W'(f_rdata);
                nxv_next = 1'b1;
                st_next = ST_RELEASED;
                state_next = S_WCLR;
            end
            S_WCLR:
            begin
                w_we = 1'b1;
                w_waddr = w_reg;
                w_wdata = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (apb_wr && paddr == 1'b0)
            begin
                mask_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pid_reg  <= pid_next;
        mid_reg  <= mid_next;
        ow_reg   <= ow_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        st_reg   <= st_next;
        nx_reg   <= nx_next;
        nxv_reg  <= nxv_next;
        w_reg    <= w_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_handoff_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && next_owner_valid) |-> (status == ST_RELEASED))
        else $error("handoff without release status");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_INVALID))
        else $error("status code out of range");
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) != S_CLR)
        else $error("result during clear sweep");
endmodule
